[design/mpi_pkg.sv]
// Shared constants and types for the minimum partition imbalance block.
`default_nettype none
package mpi_pkg;

    localparam int PX_W         = 16;   // jet momentum component width
    localparam int PT_W         = 16;   // stored jet pt width
    localparam int SQ_W         = 32;   // px^2 + py^2 width
    localparam int TOT_W        = 19;   // total and imbalance width
    localparam int JU_W         = 4;    // jets_used width
    localparam int MAX_JETS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // One command from the front to the back.
    typedef struct packed {
        logic signed [PX_W-1:0] px;
        logic signed [PX_W-1:0] py;
        logic                   jet;
        logic                   last;
    } t_cmd;

endpackage
`default_nettype wire

[design/mpi_if.sv]
// Valid/ready channel interfaces for jet words and result words.
`default_nettype none
interface mpi_jet_if;
    import mpi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [PX_W-1:0] jet_px;
    logic signed [PX_W-1:0] jet_py;
    logic                   jet_present;
    logic                   last_jet;

    modport source (output valid, output jet_px, output jet_py,
                    output jet_present, output last_jet, input ready);
    modport sink   (input valid, input jet_px, input jet_py,
                    input jet_present, input last_jet, output ready);
endinterface

interface mpi_res_if;
    import mpi_pkg::*;
    logic              valid;
    logic              ready;
    logic [TOT_W-1:0]  min_imbalance;
    logic [TOT_W-1:0]  total_pt;
    logic [JU_W-1:0]   jets_used;
    logic              jets_dropped;

    modport source (output valid, output min_imbalance, output total_pt,
                    output jets_used, output jets_dropped, input ready);
    modport sink   (input valid, input min_imbalance, input total_pt,
                    input jets_used, input jets_dropped, output ready);
endinterface
`default_nettype wire

[design/mpi_front.sv]
// Input stage: takes jet words and turns them into back-end commands.
`default_nettype none
module mpi_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mpi_jet_if.sink     i_jet,
    output mpi_pkg::t_cmd o_cmd,
    output logic        o_cmd_valid,
    input  wire logic   i_cmd_ready
);
    import mpi_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic w_accept;

    assign i_jet.ready = !r_valid || i_cmd_ready;
    assign w_accept    = i_jet.valid && i_jet.ready;

    // a word with no jet and no end marker carries nothing and is dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= i_jet.jet_present || i_jet.last_jet;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.px   <= i_jet.jet_px;
            r_cmd.py   <= i_jet.jet_py;
            r_cmd.jet  <= i_jet.jet_present;
            r_cmd.last <= i_jet.last_jet;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule
`default_nettype wire

[design/mpi_queue.sv]
// Short command FIFO between the front and the back.
`default_nettype none
module mpi_queue #(
    parameter int DEPTH = mpi_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire mpi_pkg::t_cmd i_push_cmd,
    input  wire logic    i_push_valid,
    output logic         o_push_ready,
    output mpi_pkg::t_cmd o_pop_cmd,
    output logic         o_pop_valid,
    input  wire logic    i_pop_ready
);
    import mpi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    t_cmd          r_out_cmd;
    logic          r_out_valid;
    logic          w_push;
    logic          w_pop;
    logic          w_fill;
    logic          w_rd;
    logic          w_bypass;
    logic          w_wr;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = r_out_valid;
    assign o_pop_cmd    = r_out_cmd;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = r_out_valid && i_pop_ready;

    // output register takes a new word when it is empty or being popped;
    // with the array empty the pushed word goes straight to it
    assign w_fill   = !r_out_valid || w_pop;
    assign w_rd     = w_fill && (r_cnt != '0);
    assign w_bypass = w_fill && (r_cnt == '0) && w_push;
    assign w_wr     = w_push && !w_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_fill) begin
                r_out_valid <= w_rd || w_bypass;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
        if (w_rd) begin
            r_out_cmd <= r_mem[r_rptr];
        end else if (w_bypass) begin
            r_out_cmd <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

[design/mpi_back.sv]
// Back end: pt by shared multiplier and bit-serial square root, pt store,
// Gray-code subset walk and the result register.
`default_nettype none
module mpi_back #(
    parameter int MAX_JETS = mpi_pkg::MAX_JETS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire mpi_pkg::t_cmd i_cmd,
    input  wire logic     i_cmd_valid,
    output logic          o_cmd_ready,
    mpi_res_if.source     o_res
);
    import mpi_pkg::*;

    localparam int CNT_W = $clog2(MAX_JETS + 1);
    localparam int IDX_W = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
    localparam int KW    = MAX_JETS + 1;
    localparam int SUM_W = PT_W + $clog2(MAX_JETS + 1);
    localparam int DW    = (SUM_W + 1 > TOT_W) ? SUM_W + 1 : TOT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MULX   = 3'd1;
    localparam logic [2:0] S_MULY   = 3'd2;
    localparam logic [2:0] S_SQRT   = 3'd3;
    localparam logic [2:0] S_STORE  = 3'd4;
    localparam logic [2:0] S_INIT   = 3'd5;
    localparam logic [2:0] S_SEARCH = 3'd6;
    localparam logic [2:0] S_DRAIN  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic signed [PX_W-1:0] r_px, r_py;
    logic                   r_last;
    logic [SQ_W-1:0]        r_sq;
    logic [SQ_W-1:0]        r_root;
    logic [SQ_W-1:0]        r_bit;
    logic [CNT_W-1:0]       r_count;
    logic [TOT_W-1:0]       r_total;
    logic                   r_overflow;
    logic [PT_W-1:0]        r_mem [MAX_JETS];
    logic [KW-1:0]          r_k;
    logic [PT_W-1:0]        r_rd;
    logic                   r_a_v, r_a_dir;
    logic                   r_b_v;
    logic                   r_c_v;
    logic [SUM_W-1:0]       r_sum;
    logic [DW-1:0]          r_diff;
    logic [TOT_W-1:0]       r_best;
    logic                   r_out_valid;
    logic [TOT_W-1:0]       r_out_min, r_out_total;
    logic [JU_W-1:0]        r_out_used;
    logic                   r_out_drop;

    logic                   w_pop;
    logic                   w_room;
    logic signed [2*PX_W-1:0] w_prod;
    logic [SQ_W-1:0]        w_trial;
    logic [TOT_W:0]         w_tsum;
    logic [KW-1:0]          w_lim;
    logic                   w_issue;
    logic [IDX_W-1:0]       w_idx;
    logic [KW-1:0]          w_gray;
    logic [DW-1:0]          w_twice, w_tot;
    logic                   w_empty;
    logic                   w_load;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_room      = (r_count < CNT_W'(MAX_JETS));

    assign w_prod  = (r_state == S_MULX) ? r_px * r_px : r_py * r_py;
    assign w_trial = r_root + r_bit;
    assign w_tsum  = {1'b0, r_total} + (TOT_W + 1)'(r_root[PT_W-1:0]);

    // subset walk: step k flips the jet at the lowest set bit of k
    assign w_lim   = KW'(1) << r_count;
    assign w_issue = (r_k < w_lim);
    assign w_gray  = r_k ^ (r_k >> 1);
    always_comb begin
        w_idx = '0;
        for (int j = MAX_JETS - 1; j >= 0; j--) begin
            if (r_k[j]) begin
                w_idx = IDX_W'(j);
            end
        end
    end

    assign w_twice = DW'({r_sum, 1'b0});
    assign w_tot   = DW'(r_total);
    assign w_empty = !r_a_v && !r_b_v && !r_c_v;
    assign w_load  = (r_state == S_DRAIN) && w_empty && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    if (i_cmd.jet && w_room) begin
                        n_state = S_MULX;
                    end else if (i_cmd.last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_MULX:   n_state = S_MULY;
            S_MULY:   n_state = S_SQRT;
            S_SQRT: begin
                if (r_bit[0]) begin
                    n_state = S_STORE;
                end
            end
            S_STORE:  n_state = r_last ? S_INIT : S_IDLE;
            S_INIT:   n_state = S_SEARCH;
            S_SEARCH: begin
                if (!w_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_overflow  <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a_v   <= (r_state == S_SEARCH) && w_issue;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            if (w_pop && i_cmd.jet && !w_room) begin
                r_overflow <= 1'b1;
            end
            if (r_state == S_STORE) begin
                r_count <= r_count + 1'b1;
                r_total <= (w_tsum > (TOT_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                              : w_tsum[TOT_W-1:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_total     <= '0;
                r_overflow  <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_px   <= i_cmd.px;
            r_py   <= i_cmd.py;
            r_last <= i_cmd.last;
        end
        case (r_state)
            S_MULX: begin
                r_sq <= SQ_W'($unsigned(w_prod));
            end
            S_MULY: begin
                r_sq   <= r_sq + SQ_W'($unsigned(w_prod));
                r_root <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end
            S_SQRT: begin
                if (r_sq >= w_trial) begin
                    r_sq   <= r_sq - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_INIT: begin
                r_k    <= KW'(1);
                r_sum  <= '0;
                r_best <= r_total;
            end
            S_SEARCH: begin
                if (w_issue) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_SEARCH) begin
            r_a_dir <= w_gray[w_idx];
        end
        if (r_b_v) begin
            r_diff <= (w_twice >= w_tot) ? w_twice - w_tot : w_tot - w_twice;
        end
        if (r_c_v && (r_diff < DW'(r_best))) begin
            r_best <= r_diff[TOT_W-1:0];
        end
        if (r_a_v) begin
            r_sum <= r_a_dir ? r_sum + SUM_W'(r_rd) : r_sum - SUM_W'(r_rd);
        end
        if (w_load) begin
            r_out_min   <= r_best;
            r_out_total <= r_total;
            r_out_used  <= JU_W'(r_count);
            r_out_drop  <= r_overflow;
        end
    end

    // pt store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) begin
            r_mem[r_count[IDX_W-1:0]] <= r_root[PT_W-1:0];
        end
        r_rd <= r_mem[w_idx];
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.min_imbalance = r_out_min;
    assign o_res.total_pt      = r_out_total;
    assign o_res.jets_used     = r_out_used;
    assign o_res.jets_dropped  = r_out_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JETS))
        else $error("jet count past store depth");

    a_walk_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> (r_state == S_SEARCH || r_state == S_DRAIN))
        else $error("subset walk active outside search");

    a_best_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_empty) |-> (r_best <= r_total))
        else $error("imbalance above total");

    a_event_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_count == '0 && r_total == '0 && !r_overflow && r_out_valid))
        else $error("event state not cleared after result");
`endif

endmodule
`default_nettype wire

[design/min_partition_imbalance.sv]
// Minimum two-way partition imbalance of one event's jets.
// i_jet takes one jet word per handshake (px, py in 0.25 GeV units,
// jet_present, last_jet); o_res gives one result word per event: the least
// |total - 2*subset| over all jet subsets, the total pt, jets used and an
// overflow flag. A word with no jet and no end marker is discarded.
// Each stored jet passes the back end in order: command pop, px^2 then
// py^2 on the shared 16x16 multiplier, the bit-serial square root and a
// store; no new command is taken until it is stored. A jet beyond
// MAX_JETS is popped but not stored, and sets the overflow flag. The event
// end runs a Gray-code walk over 2^n subsets, one step per cycle through
// the single read port of the pt store, between an init and a drain state.
// The front stage and command queue keep taking words while the back end
// works, until the queue and the front stage register are both full.
// A finished result sits in the output register; if the receiver stalls,
// the back end waits with the next event's end until that word is taken.
// Synchronous reset empties the queue, the event state and the output.
`default_nettype none
module min_partition_imbalance #(
    parameter int MAX_JETS    = mpi_pkg::MAX_JETS_DEF,
    parameter int QUEUE_DEPTH = mpi_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpi_jet_if.sink   i_jet,
    mpi_res_if.source o_res
);
    import mpi_pkg::*;

    t_cmd w_f_cmd;
    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_q_cmd;
    logic w_q_valid;
    logic w_q_ready;

    mpi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_jet       (i_jet),
        .o_cmd       (w_f_cmd),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready)
    );

    mpi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (w_f_cmd),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .o_pop_cmd    (w_q_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready)
    );

    mpi_back #(
        .MAX_JETS (MAX_JETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
